### hdl/mtd_pkg.sv
// Package for the Morse token decoder: job type, character constants, code lookup.
`timescale 1ns / 1ps

package mtd_pkg;

    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [2:0] LEN_MAX     = 3'd6;
    localparam logic [2:0] LEN_CODE    = 3'd5;

    // One unit of work handed from front to back.
    typedef struct packed {
        logic       eos;      // end of stream: newline follows
        logic       has_char; // a token character goes out first
        logic [7:0] ch;       // resolved token character
    } t_job;

    // Code table, indexed by (2^len - 2) + pattern; zero means no character.
    function automatic logic [7:0] code_lookup(input logic [5:0] idx);
        logic [7:0] c;
        case (idx)
            6'd0:  c = "E";  6'd1:  c = "T";
            6'd2:  c = "I";  6'd3:  c = "A";  6'd4:  c = "N";  6'd5:  c = "M";
            6'd6:  c = "S";  6'd7:  c = "U";  6'd8:  c = "R";  6'd9:  c = "W";
            6'd10: c = "D";  6'd11: c = "K";  6'd12: c = "G";  6'd13: c = "O";
            6'd14: c = "H";  6'd15: c = "V";  6'd16: c = "F";
            6'd18: c = "L";  6'd20: c = "P";  6'd21: c = "J";
            6'd22: c = "B";  6'd23: c = "X";  6'd24: c = "C";  6'd25: c = "Y";
            6'd26: c = "Z";  6'd27: c = "Q";
            6'd30: c = "5";  6'd31: c = "4";  6'd33: c = "3";  6'd37: c = "2";
            6'd45: c = "1";  6'd46: c = "6";  6'd54: c = "7";  6'd58: c = "8";
            6'd60: c = "9";  6'd61: c = "0";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Character for a finished token.
    function automatic logic [7:0] resolve_token(
        input logic [2:0] len,
        input logic [4:0] pat,
        input logic       foreign,
        input logic       slash
    );
        logic [5:0] base;
        logic [5:0] idx;
        logic [7:0] c;
        base = (6'd1 << len) - 6'd2;
        idx  = base + {1'b0, pat};
        c    = code_lookup(idx);
        if (len == 3'd1 && slash) begin
            return CH_SPACE;
        end
        if (foreign || len == 3'd0 || len > LEN_CODE || c == 8'h00) begin
            return CH_QUESTION;
        end
        return c;
    endfunction

endpackage

### hdl/morse_token_decoder.sv
// Top level of the Morse token decoder: front end, job queue, back end.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel is queue-like: drive i_kind / i_data_byte and raise push;
//   the beat is taken on a rising edge with push high and full low.
//   i_kind = 0 carries a text byte, i_kind = 1 marks end of stream.
//   Output channel is queue-like too: while empty is low, o_out_char and
//   o_last_of_run show the oldest result; pop high takes that beat.
//   Whitespace ends a token and yields one character (letter, digit, space
//   for "/", or '?'). End of stream yields the open token's character, if
//   any, then a newline flagged last.
// Timing:
//   One input beat per cycle while full is low. A token-ending beat is written
//   to the job queue at its accepting edge and moves on to the output register
//   when the output side is free. The back end issues one result beat per cycle
//   while pop takes them; an end of stream with an open token yields a character
//   beat and a newline beat, which the job queue (QUEUE_DEPTH entries) absorbs.
//   If pop is held low the output register holds its beat, the queue fills,
//   and full rises to stall the input; nothing is dropped.
// Reset: synchronous active-low i_rst_n clears token state, queue and output.
//

module morse_token_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_kind,
    input  logic [7:0] i_data_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_char,
    output logic       o_last_of_run
);

    logic          in_fire;
    logic          job_valid;
    mtd_pkg::t_job job_wr;
    mtd_pkg::t_job job_rd;
    logic          job_rd_en;
    logic          job_empty;

    // Input beats are only taken when the queue can hold a job for them.
    assign in_fire = push && !full;

    mtd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_fire),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .o_job_valid (job_valid),
        .o_job       (job_wr)
    );

    mtd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (job_valid),
        .i_wr_job (job_wr),
        .i_rd     (job_rd_en),
        .o_rd_job (job_rd),
        .o_full   (full),
        .o_empty  (job_empty)
    );

    mtd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_empty   (job_empty),
        .i_job         (job_rd),
        .o_job_rd      (job_rd_en),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run)
    );

endmodule

### hdl/mtd_front.sv
// Front end: accepts bytes, tracks the open token, issues jobs on token end or end of stream.
`timescale 1ns / 1ps

module mtd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic           i_kind,
    input  logic [7:0]     i_data_byte,
    output logic           o_job_valid,
    output mtd_pkg::t_job  o_job
);

    logic [2:0] r_len, n_len;
    logic [4:0] r_pat, n_pat;
    logic       r_foreign, n_foreign;
    logic       r_slash, n_slash;
    logic       is_ws;

    always_comb begin
        is_ws       = i_data_byte inside {8'd32, [8'd9:8'd13]};
        n_len       = r_len;
        n_pat       = r_pat;
        n_foreign   = r_foreign;
        n_slash     = r_slash;
        o_job_valid = 1'b0;
        o_job.eos      = i_kind;
        o_job.has_char = (r_len != 3'd0);
        o_job.ch       = mtd_pkg::resolve_token(r_len, r_pat, r_foreign, r_slash);
        if (i_fire) begin
            if (i_kind || is_ws) begin
                o_job_valid = i_kind || (r_len != 3'd0);
                n_len       = 3'd0;
                n_pat       = 5'd0;
                n_foreign   = 1'b0;
                n_slash     = 1'b0;
            end else begin
                if (r_len == 3'd0 && i_data_byte == mtd_pkg::CH_SLASH) begin
                    n_slash = 1'b1;
                end
                if (i_data_byte == mtd_pkg::CH_DOT || i_data_byte == mtd_pkg::CH_DASH) begin
                    n_pat = {r_pat[3:0], (i_data_byte == mtd_pkg::CH_DASH)};
                end else begin
                    n_foreign = 1'b1;
                end
                if (r_len < mtd_pkg::LEN_MAX) begin
                    n_len = r_len + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= 3'd0;
            r_pat     <= 5'd0;
            r_foreign <= 1'b0;
            r_slash   <= 1'b0;
        end else begin
            r_len     <= n_len;
            r_pat     <= n_pat;
            r_foreign <= n_foreign;
            r_slash   <= n_slash;
        end
    end

endmodule

### hdl/mtd_queue.sv
// Job queue between front and back.
`timescale 1ns / 1ps

module mtd_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  mtd_pkg::t_job  i_wr_job,
    input  logic           i_rd,
    output mtd_pkg::t_job  o_rd_job,
    output logic           o_full,
    output logic           o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    mtd_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr_ok, rd_ok;

    assign o_full   = (r_cnt == CW'(DEPTH));
    assign o_empty  = (r_cnt == '0);
    assign wr_ok    = i_wr && !o_full;
    assign rd_ok    = i_rd && !o_empty;
    assign o_rd_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + AW'(1);
            end
            if (rd_ok) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + AW'(1);
            end
            if (wr_ok && !rd_ok) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd_ok && !wr_ok) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### hdl/mtd_back.sv
// Back end: expands jobs into result beats held in an output register.
`timescale 1ns / 1ps

module mtd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_empty,
    input  mtd_pkg::t_job  i_job,
    output logic           o_job_rd,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_out_char,
    output logic           o_last_of_run
);

    logic       r_valid, n_valid;
    logic       r_nl_pend, n_nl_pend;
    logic [7:0] r_char, n_char;
    logic       r_last, n_last;
    logic       load_ok;

    assign o_empty       = !r_valid;
    assign o_out_char    = r_char;
    assign o_last_of_run = r_last;

    always_comb begin
        load_ok   = !r_valid || i_pop;
        n_valid   = r_valid;
        n_nl_pend = r_nl_pend;
        n_char    = r_char;
        n_last    = r_last;
        o_job_rd  = 1'b0;
        if (load_ok) begin
            n_valid = 1'b0;
            if (r_nl_pend) begin
                n_valid   = 1'b1;
                n_char    = mtd_pkg::CH_NEWLINE;
                n_last    = 1'b1;
                n_nl_pend = 1'b0;
            end else if (!i_job_empty) begin
                o_job_rd = 1'b1;
                n_valid  = 1'b1;
                if (i_job.eos && i_job.has_char) begin
                    n_char    = i_job.ch;
                    n_last    = 1'b0;
                    n_nl_pend = 1'b1;
                end else if (i_job.eos) begin
                    n_char = mtd_pkg::CH_NEWLINE;
                    n_last = 1'b1;
                end else begin
                    n_char = i_job.ch;
                    n_last = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_nl_pend <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_nl_pend <= n_nl_pend;
        end
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule

### test/mtd_checker.sv
// Scoreboard for the Morse token decoder: shared testbench types, character predictor, compare.
`timescale 1ns / 1ps

package mtd_tb_pkg;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_EOS  = 1'b1
    } t_beat_kind;

    // Token separators: tab, newline, vertical tab, form feed, carriage return, space.
    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

endpackage

module mtd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    input  logic       full,
    input  logic       i_kind,
    input  logic [7:0] i_data_byte,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] o_out_char,
    input  logic       o_last_of_run,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_char_count
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_beat;

    t_char_beat pending_chars[$];

    // Open token as the decoder should hold it.
    logic [2:0] tok_len;
    logic [4:0] tok_pat;
    logic       tok_foreign;
    logic       tok_slash;

    // ITU letters and digits by length and dot/dash bits (dash = 1, first symbol high).
    function automatic logic [7:0] morse_glyph(input logic [2:0] len, input logic [4:0] pat);
        logic [7:0] g;
        g = 8'h00;
        case (len)
            3'd1: begin
                g = pat[0] ? "T" : "E";
            end
            3'd2: begin
                case (pat[1:0])
                    2'b00: g = "I";
                    2'b01: g = "A";
                    2'b10: g = "N";
                    2'b11: g = "M";
                    default: g = 8'h00;
                endcase
            end
            3'd3: begin
                case (pat[2:0])
                    3'b000: g = "S";
                    3'b001: g = "U";
                    3'b010: g = "R";
                    3'b011: g = "W";
                    3'b100: g = "D";
                    3'b101: g = "K";
                    3'b110: g = "G";
                    3'b111: g = "O";
                    default: g = 8'h00;
                endcase
            end
            3'd4: begin
                case (pat[3:0])
                    4'b0000: g = "H";
                    4'b0001: g = "V";
                    4'b0010: g = "F";
                    4'b0100: g = "L";
                    4'b0110: g = "P";
                    4'b0111: g = "J";
                    4'b1000: g = "B";
                    4'b1001: g = "X";
                    4'b1010: g = "C";
                    4'b1011: g = "Y";
                    4'b1100: g = "Z";
                    4'b1101: g = "Q";
                    default: g = 8'h00;
                endcase
            end
            3'd5: begin
                case (pat)
                    5'b00000: g = "5";
                    5'b00001: g = "4";
                    5'b00011: g = "3";
                    5'b00111: g = "2";
                    5'b01111: g = "1";
                    5'b10000: g = "6";
                    5'b11000: g = "7";
                    5'b11100: g = "8";
                    5'b11110: g = "9";
                    5'b11111: g = "0";
                    default:  g = 8'h00;
                endcase
            end
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] token_char();
        logic [7:0] g;
        g = morse_glyph(tok_len, tok_pat);
        if (tok_len == 3'd1 && tok_slash) begin
            return mtd_pkg::CH_SPACE;
        end
        if (tok_foreign || tok_len == 3'd0 || tok_len > mtd_pkg::LEN_CODE
                || g == 8'h00) begin
            return mtd_pkg::CH_QUESTION;
        end
        return g;
    endfunction

    function automatic void clear_token();
        tok_len     = 3'd0;
        tok_pat     = 5'd0;
        tok_foreign = 1'b0;
        tok_slash   = 1'b0;
    endfunction

    task automatic decode_beat(input mtd_tb_pkg::t_beat_kind k, input logic [7:0] b);
        if (k == mtd_tb_pkg::KIND_EOS) begin
            if (tok_len != 3'd0) begin
                pending_chars.push_back(t_char_beat'{ch: token_char(), last: 1'b0});
            end
            pending_chars.push_back(t_char_beat'{ch: mtd_pkg::CH_NEWLINE, last: 1'b1});
            clear_token();
        end else if (mtd_tb_pkg::is_space(b)) begin
            if (tok_len != 3'd0) begin
                pending_chars.push_back(t_char_beat'{ch: token_char(), last: 1'b1});
            end
            clear_token();
        end else begin
            if (tok_len == 3'd0 && b == mtd_pkg::CH_SLASH) begin
                tok_slash = 1'b1;
            end
            if (b == mtd_pkg::CH_DOT || b == mtd_pkg::CH_DASH) begin
                tok_pat = {tok_pat[3:0], b == mtd_pkg::CH_DASH};
            end else begin
                tok_foreign = 1'b1;
            end
            if (tok_len < mtd_pkg::LEN_MAX) begin
                tok_len = tok_len + 3'd1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_char_beat want;
        if (!i_rst_n) begin
            pending_chars.delete();
            clear_token();
            o_fail_count = 0;
            o_char_count = 0;
        end else begin
            // Output side first: a beat pushed at this edge cannot be out yet.
            if (pop && !empty) begin
                o_char_count++;
                if (pending_chars.size() == 0) begin
                    $error("unexpected result: out_char %h, last_of_run %b",
                           o_out_char, o_last_of_run);
                    o_fail_count++;
                end else begin
                    want = pending_chars.pop_front();
                    if (o_out_char !== want.ch) begin
                        $error("out_char mismatch: expected %h, actual %h",
                               want.ch, o_out_char);
                        o_fail_count++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $error("last_of_run mismatch: expected %b, actual %b",
                               want.last, o_last_of_run);
                        o_fail_count++;
                    end
                end
            end
            if (push && !full) begin
                decode_beat(mtd_tb_pkg::t_beat_kind'(i_kind), i_data_byte);
            end
        end
        o_pending = pending_chars.size();
    end

endmodule

### test/tb_top.sv
// Testbench top for the Morse token decoder: clock, reset, text stimulus, handshake pacing, verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_BEATS  = 860;  // random part, split over four pacing phases
    localparam int LONG_TOKEN    = 270;  // longer than 255 bytes
    localparam int HOLD_CYCLES   = 64;   // output hold-off, long enough to back up the queue
    localparam int DRAIN_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 12;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       push        = 1'b0;
    logic       full;
    logic       i_kind      = mtd_tb_pkg::KIND_DATA;
    logic [7:0] i_data_byte = 8'h00;
    logic       empty;
    logic       pop         = 1'b0;
    logic [7:0] o_out_char;
    logic       o_last_of_run;

    int fail_count;
    int pending;
    int char_count;

    // Pacing knobs, written by the stimulus process, read by the sender and receiver.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_reqs      = 0;

    int beats_sent = 0;
    int eos_sent   = 0;

    morse_token_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .empty        (empty),
        .pop          (pop),
        .o_out_char   (o_out_char),
        .o_last_of_run(o_last_of_run)
    );

    mtd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .empty        (empty),
        .pop          (pop),
        .o_out_char   (o_out_char),
        .o_last_of_run(o_last_of_run),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_char_count (char_count)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("morse_token_decoder test failed");
        $finish;
    end

    // Receiver: pop changes on the falling edge. A hold request parks pop low for
    // HOLD_CYCLES, counted here, while the sender keeps pushing into a full block.
    initial begin
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else if (holds_done < hold_reqs) begin
                holds_done++;
                hold_left = HOLD_CYCLES - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // One input beat. Called at a falling edge, returns at the falling edge after
    // the beat is taken. push gets a single assignment per step, so back-to-back
    // beats keep it high without a glitch.
    task automatic send_beat(input mtd_tb_pkg::t_beat_kind k, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push        <= 1'b1;
        i_kind      <= k;
        i_data_byte <= b;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        beats_sent++;
        if (k == mtd_tb_pkg::KIND_EOS) begin
            eos_sent++;
        end
        @(negedge i_clk);
    endtask

    // n random dots and dashes
    task automatic send_symbols(input int n);
        repeat (n) begin
            send_beat(mtd_tb_pkg::KIND_DATA,
                      $urandom_range(0, 1) ? mtd_pkg::CH_DASH : mtd_pkg::CH_DOT);
        end
    endtask

    function automatic logic [7:0] pick_space();
        logic [7:0] b;
        b = 8'($urandom_range(8, 13));
        return (b == 8'd8) ? 8'd32 : b;
    endfunction

    // Any byte that neither separates tokens nor is a Morse symbol.
    function automatic logic [7:0] pick_foreign();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (mtd_tb_pkg::is_space(b) || b == mtd_pkg::CH_DOT || b == mtd_pkg::CH_DASH);
        return b;
    endfunction

    initial begin
        int phase;
        int phase_end;
        int sel;
        int n;

        // Reset held, then released on a falling edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- Directed part ---
        // separators with nothing open: no output
        send_beat(mtd_tb_pkg::KIND_DATA, 8'd32);
        send_beat(mtd_tb_pkg::KIND_DATA, 8'd9);
        // single dot / single dash
        send_beat(mtd_tb_pkg::KIND_DATA, mtd_pkg::CH_DOT);
        send_beat(mtd_tb_pkg::KIND_DATA, 8'd13);
        send_beat(mtd_tb_pkg::KIND_DATA, mtd_pkg::CH_DASH);
        send_beat(mtd_tb_pkg::KIND_DATA, 8'd10);
        // lone slash -> word space
        send_beat(mtd_tb_pkg::KIND_DATA, mtd_pkg::CH_SLASH);
        send_beat(mtd_tb_pkg::KIND_DATA, 8'd32);
        // byte zero and byte 0xFF are ordinary foreign bytes -> '?'
        send_beat(mtd_tb_pkg::KIND_DATA, 8'h00);
        send_beat(mtd_tb_pkg::KIND_DATA, 8'd11);
        send_beat(mtd_tb_pkg::KIND_DATA, 8'hFF);
        send_beat(mtd_tb_pkg::KIND_DATA, 8'd12);
        // six symbols: too long for any code
        send_symbols(6);
        send_beat(mtd_tb_pkg::KIND_DATA, 8'd32);
        // end of stream flushing an open slash token; data byte must be ignored
        send_beat(mtd_tb_pkg::KIND_DATA, mtd_pkg::CH_SLASH);
        send_beat(mtd_tb_pkg::KIND_EOS, 8'hFF);
        // end of stream with nothing open: newline alone
        send_beat(mtd_tb_pkg::KIND_EOS, 8'h00);
        // "..--" has no letter -> '?', then newline
        send_beat(mtd_tb_pkg::KIND_DATA, mtd_pkg::CH_DOT);
        send_beat(mtd_tb_pkg::KIND_DATA, mtd_pkg::CH_DOT);
        send_beat(mtd_tb_pkg::KIND_DATA, mtd_pkg::CH_DASH);
        send_beat(mtd_tb_pkg::KIND_DATA, mtd_pkg::CH_DASH);
        send_beat(mtd_tb_pkg::KIND_EOS, 8'h5A);

        // --- Random part: four pacing phases ---
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    // free running, with one long output hold-off at the start
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_reqs++;
                end
                1: begin
                    send_idle_pct  = 45;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 45;
                    // one token far past the length counter's range
                    send_symbols(LONG_TOKEN);
                    send_beat(mtd_tb_pkg::KIND_DATA, pick_space());
                end
                default: begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 25;
                end
            endcase
            phase_end = beats_sent + RANDOM_BEATS / 4;
            while (beats_sent < phase_end) begin
                sel = $urandom_range(0, 99);
                if (sel < 55) begin
                    // valid-length code, may or may not map to a character
                    send_symbols($urandom_range(1, 5));
                end else if (sel < 63) begin
                    send_beat(mtd_tb_pkg::KIND_DATA, mtd_pkg::CH_SLASH);
                end else if (sel < 73) begin
                    // mixed token: symbols with foreign bytes, slash may lead
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        send_beat(mtd_tb_pkg::KIND_DATA,
                                  ($urandom_range(0, 2) == 0) ? pick_foreign() :
                                  ($urandom_range(0, 1) ? mtd_pkg::CH_DASH : mtd_pkg::CH_DOT));
                    end
                end else if (sel < 83) begin
                    // over-long symbol run, crosses the length saturation
                    send_symbols($urandom_range(6, 9));
                end else begin
                    // raw noise bytes, separators included
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        send_beat(mtd_tb_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
                    end
                end
                // close the token: mostly a separator, sometimes a doubled one,
                // sometimes end of stream (flush plus newline)
                sel = $urandom_range(0, 99);
                if (sel < 88) begin
                    send_beat(mtd_tb_pkg::KIND_DATA, pick_space());
                    if (sel < 15) begin
                        send_beat(mtd_tb_pkg::KIND_DATA, pick_space());
                    end
                end else begin
                    send_beat(mtd_tb_pkg::KIND_EOS, 8'($urandom_range(0, 255)));
                end
            end
        end

        // --- Drain ---
        push           <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        n = 0;
        while (pending != 0 && n < DRAIN_LIMIT) begin
            @(negedge i_clk);
            n++;
        end
        // tail wait to catch stray extra beats
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (pending != 0) begin
            $error("%0d expected characters never came out", pending);
        end

        $display("Run covered %0d input beats including %0d end-of-stream marks,",
                 beats_sent, eos_sent);
        $display("%0d decoded characters checked over four pacing mixes and an output hold-off.",
                 char_count);
        if (fail_count == 0 && pending == 0) begin
            $display("morse_token_decoder test passed");
        end else begin
            $display("morse_token_decoder test failed");
        end
        $finish;
    end

endmodule
